// ----- hdl/gc_victim_block_scanner_core_macros.svh -----
// Assertion macros used by the scanner RTL.
`ifndef GC_VICTIM_BLOCK_SCANNER_CORE_MACROS_SVH
`define GC_VICTIM_BLOCK_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define GCVBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define GCVBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gcvbs_pkg.sv -----
package gcvbs_pkg;

    // default geometry
    localparam int DEF_CHANNELS          = 4;
    localparam int DEF_CHIPS_PER_CHANNEL = 2;
    localparam int DEF_DIES_PER_CHIP     = 2;
    localparam int DEF_PLANES_PER_DIE    = 2;
    localparam int DEF_BLOCKS_PER_PLANE  = 256;

    // saturation limit for stored counts
    localparam int PAGES_PER_BLOCK = 256;

    // count and threshold width
    localparam int CNT_W = 9;
    localparam logic [CNT_W-1:0] THR_RESET = 9'd128;

    // stream field widths
    localparam int CH_FW  = 2;
    localparam int CE_FW  = 1;
    localparam int LU_FW  = 1;
    localparam int PL_FW  = 1;
    localparam int BK_FW  = 8;

    // input tdata offsets
    localparam int TD_CH_LSB  = 0;
    localparam int TD_CE_LSB  = 2;
    localparam int TD_LU_LSB  = 3;
    localparam int TD_PL_LSB  = 4;
    localparam int TD_BK_LSB  = 5;
    localparam int TD_INV_LSB = 13;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    typedef enum logic
    {
        OP_UPDATE = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_PRIME,
        ST_SCAN,
        ST_DONE
    } state_t;

    // address field width for a dimension of n entries, at least one bit
    function automatic int field_w(input int n);
        field_w = (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ----- hdl/gcvbs_ram.sv -----
module gcvbs_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/gcvbs_addr_step.sv -----
// Mixed-radix step of a block address, plane fastest and block slowest.
module gcvbs_addr_step #(
    parameter int CHANNELS          = gcvbs_pkg::DEF_CHANNELS,
    parameter int CHIPS_PER_CHANNEL = gcvbs_pkg::DEF_CHIPS_PER_CHANNEL,
    parameter int DIES_PER_CHIP     = gcvbs_pkg::DEF_DIES_PER_CHIP,
    parameter int PLANES_PER_DIE    = gcvbs_pkg::DEF_PLANES_PER_DIE,
    parameter int BLOCKS_PER_PLANE  = gcvbs_pkg::DEF_BLOCKS_PER_PLANE,
    localparam int PL_W   = gcvbs_pkg::field_w(PLANES_PER_DIE),
    localparam int CH_W   = gcvbs_pkg::field_w(CHANNELS),
    localparam int CE_W   = gcvbs_pkg::field_w(CHIPS_PER_CHANNEL),
    localparam int LU_W   = gcvbs_pkg::field_w(DIES_PER_CHIP),
    localparam int BK_W   = gcvbs_pkg::field_w(BLOCKS_PER_PLANE),
    localparam int ADDR_W = PL_W + CH_W + CE_W + LU_W + BK_W
) (
    input  logic [ADDR_W-1:0] pos,
    output logic [ADDR_W-1:0] pos_next,
    output logic              last
);

    localparam int PL_LSB = 0;
    localparam int CH_LSB = PL_LSB + PL_W;
    localparam int CE_LSB = CH_LSB + CH_W;
    localparam int LU_LSB = CE_LSB + CE_W;
    localparam int BK_LSB = LU_LSB + LU_W;

    logic [PL_W-1:0] pl;
    logic [CH_W-1:0] ch;
    logic [CE_W-1:0] ce;
    logic [LU_W-1:0] lu;
    logic [BK_W-1:0] bk;
    logic pl_max, ch_max, ce_max, lu_max, bk_max;
    logic c_ch, c_ce, c_lu, c_bk;

    assign pl = pos[PL_LSB +: PL_W];
    assign ch = pos[CH_LSB +: CH_W];
    assign ce = pos[CE_LSB +: CE_W];
    assign lu = pos[LU_LSB +: LU_W];
    assign bk = pos[BK_LSB +: BK_W];

    assign pl_max = (pl == PL_W'(PLANES_PER_DIE - 1));
    assign ch_max = (ch == CH_W'(CHANNELS - 1));
    assign ce_max = (ce == CE_W'(CHIPS_PER_CHANNEL - 1));
    assign lu_max = (lu == LU_W'(DIES_PER_CHIP - 1));
    assign bk_max = (bk == BK_W'(BLOCKS_PER_PLANE - 1));

    // carry into each digit
    assign c_ch = pl_max;
    assign c_ce = c_ch & ch_max;
    assign c_lu = c_ce & ce_max;
    assign c_bk = c_lu & lu_max;
    assign last = c_bk & bk_max;

    always_comb
    begin
        pos_next[PL_LSB +: PL_W] = pl_max ? '0 : pl + PL_W'(1);
        pos_next[CH_LSB +: CH_W] = !c_ch ? ch : (ch_max ? '0 : ch + CH_W'(1));
        pos_next[CE_LSB +: CE_W] = !c_ce ? ce : (ce_max ? '0 : ce + CE_W'(1));
        pos_next[LU_LSB +: LU_W] = !c_lu ? lu : (lu_max ? '0 : lu + LU_W'(1));
        pos_next[BK_LSB +: BK_W] = !c_bk ? bk : (bk_max ? '0 : bk + BK_W'(1));
    end

endmodule

// ----- hdl/gc_victim_block_scanner_core.sv -----
// GC victim block scanner. Holds one invalid-page count per flash block and a
// scan cursor. An update transfer (tuser = 0) writes one block's count,
// saturated to the block size; out-of-range addresses are dropped. A search
// transfer (tuser = 1) walks the count memory from the cursor in plane,
// channel, chip, die, block order, one memory read per cycle through a single
// address stepper and threshold comparator, and stops at the first block
// whose count reaches victim_threshold; the cursor stays on that block.
// Running off the end reports not-found and returns the cursor to zero.
// A search first primes the registered memory read, then compares one block
// at a time, then loads the output register once any earlier result has been
// taken; with the default geometry it checks at most 8192 blocks. The input
// side is not ready during a search. After reset a clearing pass zeroes all
// 2**(address width) entries (8192 by default) of the count memory, with the
// input side held off; threshold writes are taken at any time.
`include "gc_victim_block_scanner_core_macros.svh"

module gc_victim_block_scanner_core #(
    parameter int CHANNELS          = gcvbs_pkg::DEF_CHANNELS,
    parameter int CHIPS_PER_CHANNEL = gcvbs_pkg::DEF_CHIPS_PER_CHANNEL,
    parameter int DIES_PER_CHIP     = gcvbs_pkg::DEF_DIES_PER_CHIP,
    parameter int PLANES_PER_DIE    = gcvbs_pkg::DEF_PLANES_PER_DIE,
    parameter int BLOCKS_PER_PLANE  = gcvbs_pkg::DEF_BLOCKS_PER_PLANE
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // channel[1:0], chip[2], die[3], plane[4], block_index[12:5],
    // invalid_pages[21:13], zero fill above
    input  logic [gcvbs_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  logic                             s_tuser,
    // master side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // victim_channel[1:0], victim_chip[2], victim_die[3], victim_plane[4],
    // victim_blk[12:5], zero fill above
    output logic [gcvbs_pkg::M_TDATA_W-1:0]  m_tdata,
    // found[0]
    output logic                             m_tuser,
    // threshold register
    input  logic                             cfg_wr_en,
    input  logic [gcvbs_pkg::CNT_W-1:0]      cfg_wr_data
);

    localparam int CNT_W  = gcvbs_pkg::CNT_W;
    localparam int CH_FW  = gcvbs_pkg::CH_FW;
    localparam int CE_FW  = gcvbs_pkg::CE_FW;
    localparam int LU_FW  = gcvbs_pkg::LU_FW;
    localparam int PL_FW  = gcvbs_pkg::PL_FW;
    localparam int BK_FW  = gcvbs_pkg::BK_FW;

    localparam int PL_W   = gcvbs_pkg::field_w(PLANES_PER_DIE);
    localparam int CH_W   = gcvbs_pkg::field_w(CHANNELS);
    localparam int CE_W   = gcvbs_pkg::field_w(CHIPS_PER_CHANNEL);
    localparam int LU_W   = gcvbs_pkg::field_w(DIES_PER_CHIP);
    localparam int BK_W   = gcvbs_pkg::field_w(BLOCKS_PER_PLANE);
    localparam int ADDR_W = PL_W + CH_W + CE_W + LU_W + BK_W;
    localparam int DEPTH  = 1 << ADDR_W;

    // address layout: {block, die, chip, channel, plane}
    localparam int PL_LSB = 0;
    localparam int CH_LSB = PL_LSB + PL_W;
    localparam int CE_LSB = CH_LSB + CH_W;
    localparam int LU_LSB = CE_LSB + CE_W;
    localparam int BK_LSB = LU_LSB + LU_W;

    localparam int M_PAD_W = gcvbs_pkg::M_TDATA_W - (CH_FW + CE_FW + LU_FW + PL_FW + BK_FW);

    gcvbs_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_reg,   clr_next;
    logic [CNT_W-1:0]  thr_reg;
    logic [ADDR_W-1:0] cur_reg,   cur_next;
    logic [ADDR_W-1:0] chk_reg,   chk_next;
    logic [ADDR_W-1:0] probe_reg, probe_next;
    logic              chk_last_reg, chk_last_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic [gcvbs_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    // input fields
    gcvbs_pkg::op_t    in_op;
    logic [CH_FW-1:0]  in_ch;
    logic [CE_FW-1:0]  in_ce;
    logic [LU_FW-1:0]  in_lu;
    logic [PL_FW-1:0]  in_pl;
    logic [BK_FW-1:0]  in_bk;
    logic [CNT_W-1:0]  in_inv;
    logic [CNT_W-1:0]  in_sat;
    logic              in_range;
    logic              in_acc;

    logic [CH_W+CH_FW-1:0] in_ch_ext;
    logic [CE_W+CE_FW-1:0] in_ce_ext;
    logic [LU_W+LU_FW-1:0] in_lu_ext;
    logic [PL_W+PL_FW-1:0] in_pl_ext;
    logic [BK_W+BK_FW-1:0] in_bk_ext;
    logic [ADDR_W-1:0]     in_addr;

    // victim address fields from the checked position
    logic [CH_W+CH_FW-1:0] vo_ch_ext;
    logic [CE_W+CE_FW-1:0] vo_ce_ext;
    logic [LU_W+LU_FW-1:0] vo_lu_ext;
    logic [PL_W+PL_FW-1:0] vo_pl_ext;
    logic [BK_W+BK_FW-1:0] vo_bk_ext;

    // memory port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;

    // shared stepper
    logic [ADDR_W-1:0] step_in;
    logic [ADDR_W-1:0] step_out;
    logic              step_last;
    logic              hit;

    assign in_op  = gcvbs_pkg::op_t'(s_tuser);
    assign in_ch  = s_tdata[gcvbs_pkg::TD_CH_LSB  +: CH_FW];
    assign in_ce  = s_tdata[gcvbs_pkg::TD_CE_LSB  +: CE_FW];
    assign in_lu  = s_tdata[gcvbs_pkg::TD_LU_LSB  +: LU_FW];
    assign in_pl  = s_tdata[gcvbs_pkg::TD_PL_LSB  +: PL_FW];
    assign in_bk  = s_tdata[gcvbs_pkg::TD_BK_LSB  +: BK_FW];
    assign in_inv = s_tdata[gcvbs_pkg::TD_INV_LSB +: CNT_W];

    assign in_range = (32'(in_ch) < CHANNELS) && (32'(in_ce) < CHIPS_PER_CHANNEL)
                   && (32'(in_lu) < DIES_PER_CHIP) && (32'(in_pl) < PLANES_PER_DIE)
                   && (32'(in_bk) < BLOCKS_PER_PLANE);

    // clamp to block size
    assign in_sat = (32'(in_inv) > gcvbs_pkg::PAGES_PER_BLOCK)
                  ? CNT_W'(gcvbs_pkg::PAGES_PER_BLOCK) : in_inv;

    // fit the stream fields to the address digit widths
    assign in_ch_ext = {{CH_W{1'b0}}, in_ch};
    assign in_ce_ext = {{CE_W{1'b0}}, in_ce};
    assign in_lu_ext = {{LU_W{1'b0}}, in_lu};
    assign in_pl_ext = {{PL_W{1'b0}}, in_pl};
    assign in_bk_ext = {{BK_W{1'b0}}, in_bk};
    assign in_addr   = {in_bk_ext[BK_W-1:0], in_lu_ext[LU_W-1:0], in_ce_ext[CE_W-1:0],
                        in_ch_ext[CH_W-1:0], in_pl_ext[PL_W-1:0]};

    assign vo_ch_ext = {{CH_FW{1'b0}}, chk_reg[CH_LSB +: CH_W]};
    assign vo_ce_ext = {{CE_FW{1'b0}}, chk_reg[CE_LSB +: CE_W]};
    assign vo_lu_ext = {{LU_FW{1'b0}}, chk_reg[LU_LSB +: LU_W]};
    assign vo_pl_ext = {{PL_FW{1'b0}}, chk_reg[PL_LSB +: PL_W]};
    assign vo_bk_ext = {{BK_FW{1'b0}}, chk_reg[BK_LSB +: BK_W]};

    assign s_tready = (state_reg == gcvbs_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // clearing pass owns the write port until it is done
    assign ram_we    = (state_reg == gcvbs_pkg::ST_CLEAR)
                    || (in_acc && (in_op == gcvbs_pkg::OP_UPDATE) && in_range);
    assign ram_waddr = (state_reg == gcvbs_pkg::ST_CLEAR) ? clr_reg : in_addr;
    assign ram_wdata = (state_reg == gcvbs_pkg::ST_CLEAR) ? '0 : in_sat;

    // scan reads one position ahead of the one being compared
    assign ram_raddr = (state_reg == gcvbs_pkg::ST_SCAN) ? probe_reg : chk_reg;

    assign step_in = (state_reg == gcvbs_pkg::ST_PRIME) ? chk_reg : probe_reg;
    assign hit     = (ram_rdata >= thr_reg);

    gcvbs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gcvbs_addr_step #(
        .CHANNELS          (CHANNELS),
        .CHIPS_PER_CHANNEL (CHIPS_PER_CHANNEL),
        .DIES_PER_CHIP     (DIES_PER_CHIP),
        .PLANES_PER_DIE    (PLANES_PER_DIE),
        .BLOCKS_PER_PLANE  (BLOCKS_PER_PLANE)
    ) u_step (
        .pos      (step_in),
        .pos_next (step_out),
        .last     (step_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gcvbs_pkg::ST_CLEAR;
            clr_reg       <= '0;
            thr_reg       <= gcvbs_pkg::THR_RESET;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        chk_reg       <= chk_next;
        probe_reg     <= probe_next;
        chk_last_reg  <= chk_last_next;
        found_reg     <= found_next;
        out_found_reg <= out_found_next;
        out_data_reg  <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        chk_next       = chk_reg;
        probe_next     = probe_reg;
        chk_last_next  = chk_last_reg;
        found_next     = found_reg;
        out_found_next = out_found_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            gcvbs_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (&clr_reg)
                begin
                    state_next = gcvbs_pkg::ST_IDLE;
                end
            end
            gcvbs_pkg::ST_IDLE:
            begin
                if (in_acc && (in_op == gcvbs_pkg::OP_SEARCH))
                begin
                    chk_next   = cur_reg;
                    state_next = gcvbs_pkg::ST_PRIME;
                end
            end
            gcvbs_pkg::ST_PRIME:
            begin
                // read of the cursor entry is in flight
                probe_next    = step_out;
                chk_last_next = step_last;
                state_next    = gcvbs_pkg::ST_SCAN;
            end
            gcvbs_pkg::ST_SCAN:
            begin
                priority if (hit)
                begin
                    found_next = 1'b1;
                    cur_next   = chk_reg;
                    state_next = gcvbs_pkg::ST_DONE;
                end
                else if (chk_last_reg)
                begin
                    found_next = 1'b0;
                    cur_next   = '0;
                    state_next = gcvbs_pkg::ST_DONE;
                end
                else
                begin
                    chk_next      = probe_reg;
                    chk_last_next = step_last;
                    probe_next    = step_out;
                end
            end
            gcvbs_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    if (found_reg)
                    begin
                        out_data_next = {{M_PAD_W{1'b0}}, vo_bk_ext[BK_FW-1:0],
                                         vo_pl_ext[PL_FW-1:0], vo_lu_ext[LU_FW-1:0],
                                         vo_ce_ext[CE_FW-1:0], vo_ch_ext[CH_FW-1:0]};
                    end
                    else
                    begin
                        out_data_next = '0;
                    end
                    state_next = gcvbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gcvbs_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_found_reg;

    // assertions
    `GCVBS_ASSERT_NOW(a_nf_zero, m_tvalid && !m_tuser, m_tdata == '0,
        "not-found result carries a non-zero address")
    `GCVBS_ASSERT_NOW(a_cur_range,
        1'b1,
        (32'(cur_reg[CH_LSB +: CH_W]) < CHANNELS)
            && (32'(cur_reg[BK_LSB +: BK_W]) < BLOCKS_PER_PLANE)
            && (32'(cur_reg[PL_LSB +: PL_W]) < PLANES_PER_DIE),
        "scan cursor outside the block geometry")
    `GCVBS_ASSERT_NEXT(a_search_prime,
        in_acc && (in_op == gcvbs_pkg::OP_SEARCH),
        state_reg == gcvbs_pkg::ST_PRIME,
        "search transfer did not start the scan")
    `GCVBS_ASSERT_NOW(a_no_wr_scan,
        (state_reg == gcvbs_pkg::ST_SCAN) || (state_reg == gcvbs_pkg::ST_PRIME),
        !ram_we,
        "count memory written during a scan")

endmodule

// ----- sim/gcvbs_victim_checker.sv -----
`timescale 1ns / 100ps

// Watches both stream channels and the threshold port, keeps its own copy of
// the count memory and cursor, and compares every result transfer.
module gcvbs_victim_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [gcvbs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [gcvbs_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                             m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [gcvbs_pkg::CNT_W-1:0]      cfg_wr_data,
    output int                               mismatch_count,
    output int                               pending
);

    localparam int DEF_CHANNELS          = gcvbs_pkg::DEF_CHANNELS;
    localparam int DEF_CHIPS_PER_CHANNEL = gcvbs_pkg::DEF_CHIPS_PER_CHANNEL;
    localparam int DEF_DIES_PER_CHIP     = gcvbs_pkg::DEF_DIES_PER_CHIP;
    localparam int DEF_PLANES_PER_DIE    = gcvbs_pkg::DEF_PLANES_PER_DIE;
    localparam int DEF_BLOCKS_PER_PLANE  = gcvbs_pkg::DEF_BLOCKS_PER_PLANE;
    localparam int PAGES_PER_BLOCK       = gcvbs_pkg::PAGES_PER_BLOCK;
    localparam int CNT_W                 = gcvbs_pkg::CNT_W;
    localparam int CH_FW                 = gcvbs_pkg::CH_FW;
    localparam int CE_FW                 = gcvbs_pkg::CE_FW;
    localparam int LU_FW                 = gcvbs_pkg::LU_FW;
    localparam int PL_FW                 = gcvbs_pkg::PL_FW;
    localparam int BK_FW                 = gcvbs_pkg::BK_FW;
    localparam int TD_CH_LSB             = gcvbs_pkg::TD_CH_LSB;
    localparam int TD_CE_LSB             = gcvbs_pkg::TD_CE_LSB;
    localparam int TD_LU_LSB             = gcvbs_pkg::TD_LU_LSB;
    localparam int TD_PL_LSB             = gcvbs_pkg::TD_PL_LSB;
    localparam int TD_BK_LSB             = gcvbs_pkg::TD_BK_LSB;
    localparam int TD_INV_LSB            = gcvbs_pkg::TD_INV_LSB;

    localparam int TOTAL_BLOCKS = DEF_CHANNELS * DEF_CHIPS_PER_CHANNEL * DEF_DIES_PER_CHIP
                                * DEF_PLANES_PER_DIE * DEF_BLOCKS_PER_PLANE;
    localparam int IDX_W        = $clog2(TOTAL_BLOCKS);
    localparam int VIC_W        = CH_FW + CE_FW + LU_FW + PL_FW + BK_FW;
    localparam int REPORT_MAX   = 10;

    // packed so that {found, m_tdata[VIC_W-1:0]} maps straight onto it
    typedef struct packed
    {
        logic             found;
        logic [BK_FW-1:0] blk;
        logic [PL_FW-1:0] pl;
        logic [LU_FW-1:0] lu;
        logic [CE_FW-1:0] ce;
        logic [CH_FW-1:0] ch;
    } victim_t;

    logic [CNT_W-1:0] count_mem [TOTAL_BLOCKS];
    int unsigned      cursor_pos;
    logic [CNT_W-1:0] thr_shadow;
    victim_t          victim_q [$];

    victim_t          want;
    victim_t          got;
    logic [CNT_W-1:0] new_count;
    int unsigned      slot;

    // plane fastest, then channel, chip, die; block index slowest
    function automatic int unsigned block_slot(input int unsigned ch, input int unsigned ce,
                                               input int unsigned lu, input int unsigned pl,
                                               input int unsigned blk);
        block_slot = (((blk * DEF_DIES_PER_CHIP + lu) * DEF_CHIPS_PER_CHANNEL + ce)
                      * DEF_CHANNELS + ch) * DEF_PLANES_PER_DIE + pl;
    endfunction

    // walks from the cursor to the first block at or above threshold
    function automatic victim_t find_victim();
        int unsigned pos;
        int unsigned rest;
        victim_t     v;
        pos = (cursor_pos >= TOTAL_BLOCKS) ? 0 : cursor_pos;
        while (pos < TOTAL_BLOCKS && count_mem[IDX_W'(pos)] < thr_shadow)
            pos++;
        v = '0;
        if (pos >= TOTAL_BLOCKS)
            cursor_pos = 0;
        else
        begin
            cursor_pos = pos;
            rest       = pos;
            v.found    = 1'b1;
            v.pl       = PL_FW'(rest % DEF_PLANES_PER_DIE);
            rest       = rest / DEF_PLANES_PER_DIE;
            v.ch       = CH_FW'(rest % DEF_CHANNELS);
            rest       = rest / DEF_CHANNELS;
            v.ce       = CE_FW'(rest % DEF_CHIPS_PER_CHANNEL);
            rest       = rest / DEF_CHIPS_PER_CHANNEL;
            v.lu       = LU_FW'(rest % DEF_DIES_PER_CHIP);
            rest       = rest / DEF_DIES_PER_CHIP;
            v.blk      = BK_FW'(rest);
        end
        return v;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $realtime, name, exp_val, act_val);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_BLOCKS; i++)
                count_mem[IDX_W'(i)] = '0;
            cursor_pos = 0;
            thr_shadow = gcvbs_pkg::THR_RESET;
            victim_q.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
                thr_shadow = cfg_wr_data;

            if (s_tvalid && s_tready)
            begin
                if (gcvbs_pkg::op_t'(s_tuser) == gcvbs_pkg::OP_SEARCH)
                    victim_q.push_back(find_victim());
                else if (s_tdata[TD_CH_LSB +: CH_FW] < DEF_CHANNELS
                      && s_tdata[TD_CE_LSB +: CE_FW] < DEF_CHIPS_PER_CHANNEL
                      && s_tdata[TD_LU_LSB +: LU_FW] < DEF_DIES_PER_CHIP
                      && s_tdata[TD_PL_LSB +: PL_FW] < DEF_PLANES_PER_DIE
                      && s_tdata[TD_BK_LSB +: BK_FW] < DEF_BLOCKS_PER_PLANE)
                begin
                    new_count = s_tdata[TD_INV_LSB +: CNT_W];
                    if (new_count > PAGES_PER_BLOCK)
                        new_count = CNT_W'(PAGES_PER_BLOCK);
                    slot = block_slot(32'(s_tdata[TD_CH_LSB +: CH_FW]),
                                      32'(s_tdata[TD_CE_LSB +: CE_FW]),
                                      32'(s_tdata[TD_LU_LSB +: LU_FW]),
                                      32'(s_tdata[TD_PL_LSB +: PL_FW]),
                                      32'(s_tdata[TD_BK_LSB +: BK_FW]));
                    count_mem[IDX_W'(slot)] = new_count;
                end
            end

            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[VIC_W-1:0]};
                if (victim_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: result with nothing outstanding, found %0d data %h",
                                 $realtime, m_tuser, m_tdata);
                end
                else
                begin
                    want = victim_q.pop_front();
                    check_field("found", 32'(want.found), 32'(got.found));
                    check_field("victim_channel", 32'(want.ch), 32'(got.ch));
                    check_field("victim_chip", 32'(want.ce), 32'(got.ce));
                    check_field("victim_die", 32'(want.lu), 32'(got.lu));
                    check_field("victim_plane", 32'(want.pl), 32'(got.pl));
                    check_field("victim_blk", 32'(want.blk), 32'(got.blk));
                end
            end

            pending = victim_q.size();
        end
    end

endmodule

// ----- sim/gc_victim_block_scanner_core_tb.sv -----
`timescale 1ns / 100ps

module gc_victim_block_scanner_core_tb;

    localparam int      S_TDATA_W       = gcvbs_pkg::S_TDATA_W;
    localparam int      M_TDATA_W       = gcvbs_pkg::M_TDATA_W;
    localparam int      CNT_W           = gcvbs_pkg::CNT_W;
    localparam int      CH_FW           = gcvbs_pkg::CH_FW;
    localparam int      CE_FW           = gcvbs_pkg::CE_FW;
    localparam int      LU_FW           = gcvbs_pkg::LU_FW;
    localparam int      PL_FW           = gcvbs_pkg::PL_FW;
    localparam int      BK_FW           = gcvbs_pkg::BK_FW;
    localparam int      TD_CH_LSB       = gcvbs_pkg::TD_CH_LSB;
    localparam int      TD_CE_LSB       = gcvbs_pkg::TD_CE_LSB;
    localparam int      TD_LU_LSB       = gcvbs_pkg::TD_LU_LSB;
    localparam int      TD_PL_LSB       = gcvbs_pkg::TD_PL_LSB;
    localparam int      TD_BK_LSB       = gcvbs_pkg::TD_BK_LSB;
    localparam int      TD_INV_LSB      = gcvbs_pkg::TD_INV_LSB;

    localparam int      CLK_HALF        = 4;
    localparam int      RESET_CYCLES    = 9;
    // updates are written as they are taken, so a short settle covers anything in flight
    localparam int      SETTLE_CYCLES   = 16;
    localparam int      PHASES          = 6;
    localparam int      ITEMS_PER_PHASE = 13;
    // worst case is a full walk of the count memory per search; this allows several times that
    localparam longint  TIMEOUT_NS      = 40_000_000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // channel[1:0], chip[2], die[3], plane[4], block_index[12:5],
    // invalid_pages[21:13], zero fill above
    logic [S_TDATA_W-1:0]   s_tdata;
    // op[0]
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // victim_channel[1:0], victim_chip[2], victim_die[3], victim_plane[4],
    // victim_blk[12:5], zero fill above
    logic [M_TDATA_W-1:0]   m_tdata;
    // found[0]
    logic                   m_tuser;
    logic                   cfg_wr_en;
    logic [CNT_W-1:0]       cfg_wr_data;

    int                     mismatch_count;
    int                     pending;
    // random idling on both sides; cleared for the closing phase
    bit                     idle_on;

    int                     phase_thr [PHASES] = '{1, 256, 0, 200, 0, 128};
    int                     thr;

    gc_victim_block_scanner_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    gcvbs_victim_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    // Input side: one transfer per call. Entered and left on a falling edge, so
    // tvalid stays high across back-to-back transfers without a glitch.
    task automatic push_item(input gcvbs_pkg::op_t op, input logic [CH_FW-1:0] ch,
                             input logic [CE_FW-1:0] ce, input logic [LU_FW-1:0] lu,
                             input logic [PL_FW-1:0] pl, input logic [BK_FW-1:0] blk,
                             input logic [CNT_W-1:0] inv);
        logic [S_TDATA_W-1:0] word;
        begin
            word                         = '0;
            word[TD_CH_LSB  +: CH_FW]    = ch;
            word[TD_CE_LSB  +: CE_FW]    = ce;
            word[TD_LU_LSB  +: LU_FW]    = lu;
            word[TD_PL_LSB  +: PL_FW]    = pl;
            word[TD_BK_LSB  +: BK_FW]    = blk;
            word[TD_INV_LSB +: CNT_W]    = inv;
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                // gap with junk on the bus; must not be taken as a transfer
                s_tvalid = 1'b0;
                s_tdata  = S_TDATA_W'($urandom);
                s_tuser  = 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            s_tdata  = word;
            s_tuser  = op;
            s_tvalid = 1'b1;
            do
                @(posedge clk);
            while (!s_tready);
            @(negedge clk);
        end
    endtask

    task automatic send_update(input int ch, input int ce, input int lu, input int pl,
                               input int blk, input int inv);
        push_item(gcvbs_pkg::OP_UPDATE, CH_FW'(ch), CE_FW'(ce), LU_FW'(lu), PL_FW'(pl),
                  BK_FW'(blk), CNT_W'(inv));
    endtask

    // address and count fields are don't-care for a search; randomise them anyway
    task automatic send_search();
        push_item(gcvbs_pkg::OP_SEARCH, CH_FW'($urandom_range(0, 3)),
                  CE_FW'($urandom_range(0, 1)), LU_FW'($urandom_range(0, 1)),
                  PL_FW'($urandom_range(0, 1)), BK_FW'($urandom_range(0, 255)),
                  CNT_W'($urandom_range(0, 511)));
    endtask

    // Hold the input side off until every outstanding search has reported.
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Threshold writes only on an idle block.
    task automatic set_threshold(input int value);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = CNT_W'(value);
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // Mostly updates clustered on the first few block indices (the front of the
    // scan order) with counts around the threshold, so that searches hit, stick
    // on a victim and then move on once it is retired with a low count.
    task automatic random_item(input int cur_thr);
        int pick;
        int inv;
        int blk;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 36)
                send_search();
            else
            begin
                if ($urandom_range(0, 9) < 7)
                    blk = $urandom_range(0, 3);
                else
                    blk = $urandom_range(0, 255);
                pick = $urandom_range(0, 9);
                if (pick < 4)
                begin
                    inv = cur_thr + int'($urandom_range(0, 4)) - 2;
                    if (inv < 0)
                        inv = 0;
                end
                else if (pick < 7)
                    inv = $urandom_range(0, 511);
                else
                    inv = 0;
                send_update($urandom_range(0, 3), $urandom_range(0, 1),
                            $urandom_range(0, 1), $urandom_range(0, 1), blk, inv);
            end
        end
    endtask

    // Output side: ready in random bursts, with random low gaps while idling is on.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge clk);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = gcvbs_pkg::OP_UPDATE;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = gcvbs_pkg::THR_RESET;
        idle_on     = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed part, reset threshold of 128 ---
        // empty memory: nothing qualifies, full walk, not found
        send_search();
        // oversize count on the very last block saturates to the block size
        send_update(3, 1, 1, 1, 255, 511);
        send_update(1, 0, 0, 1, 2, 128);      // exactly at threshold
        send_update(2, 1, 0, 0, 1, 256);      // exactly the block size
        send_update(0, 0, 0, 0, 0, 127);      // one below threshold
        send_search();                        // block 1 entry comes first
        send_search();                        // cursor stays on the victim
        send_update(2, 1, 0, 0, 1, 0);        // retire it
        send_search();
        send_update(1, 0, 0, 1, 2, 257);      // just over the block size
        send_search();
        send_update(1, 0, 0, 1, 2, 0);
        send_search();                        // all-ones address at the end
        // zero threshold: the block under the cursor is reported
        set_threshold(0);
        send_search();
        // threshold out of reach once the last block drops below it
        set_threshold(256);
        send_update(3, 1, 1, 1, 255, 255);
        send_search();                        // not found, cursor back to zero
        set_threshold(0);
        send_search();                        // found at the all-zero address
        set_threshold(128);
        send_update(0, 0, 0, 0, 0, 128);
        send_search();
        send_update(0, 0, 0, 0, 0, 0);

        // --- random part, one threshold per phase ---
        for (int ph = 0; ph < PHASES; ph++)
        begin
            thr = (ph == 4) ? int'($urandom_range(0, 256)) : phase_thr[ph];
            if (ph == PHASES - 1)
                idle_on = 1'b0;
            set_threshold(thr);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_item(thr);
        end

        drain();
        if (mismatch_count == 0 && pending == 0)
            $display("gc_victim_block_scanner_core_tb: PASS");
        else
            $display("gc_victim_block_scanner_core_tb: FAIL");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("gc_victim_block_scanner_core_tb: FAIL");
        $finish;
    end

endmodule
